// ----- hdl/nsf_pkg.sv -----
// Shared types, constants and helpers for the NMEA sentence framer.
`default_nettype none

package nsf_pkg;

  localparam int unsigned MaxLen   = 128;  // longest frame before abort
  localparam int unsigned MinLen   = 10;   // shorter closed frames are short
  localparam int unsigned LenW     = 8;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned HdrW     = 48;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 48;
  localparam int unsigned NumHdr   = 3;

  localparam logic [ByteW-1:0] StartReset = 8'h24;
  localparam logic [ByteW-1:0] StopReset  = 8'h0A;
  localparam logic [HdrW-1:0]  HdrAReset  = 48'h244750524D43;  // $GPRMC
  localparam logic [HdrW-1:0]  HdrBReset  = 48'h244244524D43;  // $BDRMC
  localparam logic [HdrW-1:0]  HdrCReset  = 48'h24474E524D43;  // $GNRMC

  typedef enum logic [1:0] {
    NSF_OK       = 2'd0,
    NSF_MISMATCH = 2'd1,
    NSF_SHORT    = 2'd2,
    NSF_OVERFLOW = 2'd3
  } nsf_status_e;

  typedef enum logic [CfgIdxW-1:0] {
    NSF_CFG_START  = 3'd0,
    NSF_CFG_STOP   = 3'd1,
    NSF_CFG_HDR_A  = 3'd2,
    NSF_CFG_HDR_B  = 3'd3,
    NSF_CFG_HDR_C  = 3'd4
  } nsf_cfg_idx_e;

  typedef enum logic [1:0] {
    NSF_TYPE_NONE = 2'd0,
    NSF_TYPE_A    = 2'd1,
    NSF_TYPE_B    = 2'd2,
    NSF_TYPE_C    = 2'd3
  } nsf_type_e;

  typedef struct packed {
    nsf_status_e      status;
    nsf_type_e        stype;
    logic [LenW-1:0]  frame_len;
    logic [ByteW-1:0] calc_sum;
    logic [ByteW-1:0] recv_sum;
  } nsf_result_t;

  // {valid, value}: valid is set for 0-9, a-f, A-F
  function automatic logic [4:0] hex_digit(input logic [ByteW-1:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/nsf_frame_judge.sv -----
// Judges a closing or aborted frame: overflow, length, checksum and header match.
`default_nettype none

module nsf_frame_judge (
  input  wire logic [nsf_pkg::LenW-1:0]  len_i,       // length incl. this byte
  input  wire logic                      overflow_i,  // frame ran past the limit
  input  wire logic [nsf_pkg::ByteW-1:0] xor_i,       // XOR before this byte
  input  wire logic [nsf_pkg::ByteW-1:0] recent_i [4],// last four bytes, 0 newest
  input  wire logic [nsf_pkg::HdrW-1:0]  hdr_i,
  input  wire logic [nsf_pkg::HdrW-1:0]  hdr_cfg_i [nsf_pkg::NumHdr],
  output nsf_pkg::nsf_result_t           result_o
);

  logic [nsf_pkg::ByteW-1:0] calc;
  logic [nsf_pkg::ByteW-1:0] recv;
  logic [4:0]                hi;
  logic [4:0]                lo;
  nsf_pkg::nsf_type_e        stype;

  // The newest byte enters and leaves the span at once, so it drops out.
  assign calc = xor_i ^ recent_i[0] ^ recent_i[1] ^ recent_i[2] ^ recent_i[3];
  assign hi   = nsf_pkg::hex_digit(recent_i[2]);
  assign lo   = nsf_pkg::hex_digit(recent_i[1]);

  always_comb begin
    recv = '0;
    if (hi[4]) begin
      recv = lo[4] ? {hi[3:0], lo[3:0]} : {4'd0, hi[3:0]};
    end
  end

  // later header wins
  always_comb begin
    priority if (hdr_i == hdr_cfg_i[2]) begin
      stype = nsf_pkg::NSF_TYPE_C;
    end else if (hdr_i == hdr_cfg_i[1]) begin
      stype = nsf_pkg::NSF_TYPE_B;
    end else if (hdr_i == hdr_cfg_i[0]) begin
      stype = nsf_pkg::NSF_TYPE_A;
    end else begin
      stype = nsf_pkg::NSF_TYPE_NONE;
    end
  end

  always_comb begin
    result_o.frame_len = len_i;
    result_o.stype     = nsf_pkg::NSF_TYPE_NONE;
    result_o.calc_sum  = '0;
    result_o.recv_sum  = '0;
    priority if (overflow_i) begin
      result_o.status = nsf_pkg::NSF_OVERFLOW;
    end else if (len_i < nsf_pkg::LenW'(nsf_pkg::MinLen)) begin
      result_o.status = nsf_pkg::NSF_SHORT;
    end else if (calc == recv) begin
      result_o.status   = nsf_pkg::NSF_OK;
      result_o.stype    = stype;
      result_o.calc_sum = calc;
      result_o.recv_sum = recv;
    end else begin
      result_o.status   = nsf_pkg::NSF_MISMATCH;
      result_o.calc_sum = calc;
      result_o.recv_sum = recv;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/nmea_sentence_framer.sv -----
// Top level: NMEA sentence framer with checksum check and header match.
//
// Usage:
//   s_axis carries one received character per beat in tdata[7:0]. Bytes are
//   dropped until start_char, then every byte belongs to the frame until
//   stop_char closes it or the frame runs past MaxLen bytes.
//   m_axis gives one beat per closed or aborted frame.
//   cfg carries register writes (index 0 start_char, 1 stop_char, 2..4
//   headers a..c); always ready, unknown indexes are dropped. Write only
//   while no frame is open.
// Latency: the result beat is valid the cycle after the stop byte's beat.
// Throughput: one byte per cycle while s_axis_tready is high; the frame state
//   is updated on every accepted byte and the output register on every frame end.
// Reset: registers return to defaults ($, LF, $GPRMC, $BDRMC, $GNRMC), the
//   framer goes idle and the output register empties.
// Stall: s_axis_tready drops only while a result sits in the output
//   register and m_axis_tready is low; nothing is lost or repeated.
`default_nettype none

module nmea_sentence_framer (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // input stream
  input  wire logic                          s_axis_tvalid,
  output      logic                          s_axis_tready,
  input  wire logic [7:0]                    s_axis_tdata,   // [7:0] byte_in
  // result stream
  output      logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output      logic [23:0]                   m_axis_tdata,   // [7:0] frame_len,
                                                             // [15:8] calc_sum,
                                                             // [23:16] recv_sum
  output      logic [3:0]                    m_axis_tuser,   // [1:0] status,
                                                             // [3:2] sentence_type
  // configuration writes
  input  wire logic                          cfg_valid_i,
  output      logic                          cfg_ready_o,
  input  wire logic [nsf_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [nsf_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned ByteW = nsf_pkg::ByteW;
  localparam int unsigned LenW  = nsf_pkg::LenW;
  localparam int unsigned HdrW  = nsf_pkg::HdrW;

  // ---------------- configuration registers ----------------
  logic [ByteW-1:0] start_q;
  logic [ByteW-1:0] stop_q;
  logic [HdrW-1:0]  hdr_cfg_q [nsf_pkg::NumHdr];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q      <= nsf_pkg::StartReset;
      stop_q       <= nsf_pkg::StopReset;
      hdr_cfg_q[0] <= nsf_pkg::HdrAReset;
      hdr_cfg_q[1] <= nsf_pkg::HdrBReset;
      hdr_cfg_q[2] <= nsf_pkg::HdrCReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        nsf_pkg::NSF_CFG_START: start_q      <= cfg_data_i[ByteW-1:0];
        nsf_pkg::NSF_CFG_STOP:  stop_q       <= cfg_data_i[ByteW-1:0];
        nsf_pkg::NSF_CFG_HDR_A: hdr_cfg_q[0] <= cfg_data_i[HdrW-1:0];
        nsf_pkg::NSF_CFG_HDR_B: hdr_cfg_q[1] <= cfg_data_i[HdrW-1:0];
        nsf_pkg::NSF_CFG_HDR_C: hdr_cfg_q[2] <= cfg_data_i[HdrW-1:0];
        default: ;  // index outside the register list
      endcase
    end
  end

  // ---------------- frame state ----------------
  // len_q == 0 means idle (no frame open)
  logic [LenW-1:0]  len_q,    len_d;
  logic [ByteW-1:0] xor_q,    xor_d;
  logic [HdrW-1:0]  hdr_q,    hdr_d;
  logic [ByteW-1:0] recent_q [5];
  logic [ByteW-1:0] recent_d [5];

  logic             in_beat;
  logic [ByteW-1:0] b;
  logic [LenW-1:0]  len_inc;
  logic             is_stop;
  logic             overflow;
  logic             emit;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign b             = s_axis_tdata;
  assign len_inc       = len_q + LenW'(1);
  assign is_stop       = (b == stop_q);
  assign overflow      = !is_stop && (len_inc > LenW'(nsf_pkg::MaxLen));
  // frame closes on the stop byte or aborts on overflow
  assign emit          = in_beat && (len_q != '0) && (is_stop || overflow);

  always_comb begin
    len_d    = len_q;
    xor_d    = xor_q;
    hdr_d    = hdr_q;
    recent_d = recent_q;
    if (in_beat) begin
      if (len_q == '0) begin
        if (b == start_q) begin
          len_d       = LenW'(1);
          hdr_d       = HdrW'(b);
          recent_d[0] = b;
        end
      end else if (emit) begin
        len_d    = '0;
        xor_d    = '0;
        hdr_d    = '0;
        recent_d = '{default: '0};
      end else begin
        len_d = len_inc;
        xor_d = xor_q ^ b;
        if (len_q < LenW'(6)) begin
          hdr_d = {hdr_q[HdrW-ByteW-1:0], b};
        end
        recent_d = '{b, recent_q[0], recent_q[1], recent_q[2], recent_q[3]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      xor_q    <= '0;
      hdr_q    <= '0;
      recent_q <= '{default: '0};
    end else begin
      len_q    <= len_d;
      xor_q    <= xor_d;
      hdr_q    <= hdr_d;
      recent_q <= recent_d;
    end
  end

  // ---------------- frame judgment ----------------
  nsf_pkg::nsf_result_t result;
  logic [ByteW-1:0]     judge_recent [4];

  assign judge_recent = '{recent_q[0], recent_q[1], recent_q[2], recent_q[3]};

  nsf_frame_judge u_judge (
    .len_i      (len_inc),
    .overflow_i (overflow),
    .xor_i      (xor_q),
    .recent_i   (judge_recent),
    .hdr_i      (hdr_q),
    .hdr_cfg_i  (hdr_cfg_q),
    .result_o   (result)
  );

  // ---------------- output register ----------------
  logic                 out_valid_q, out_valid_d;
  nsf_pkg::nsf_result_t out_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.recv_sum, out_q.calc_sum, out_q.frame_len};
  assign m_axis_tuser  = {out_q.stype, out_q.status};

endmodule

`default_nettype wire

// ----- hdl/nsf_checker.sv -----
// Port-level checks on the framer's result stream, bound to the top level.
`default_nettype none

module nsf_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic [3:0]  m_axis_tuser
);

  // a held result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // a header match only comes with a good checksum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[3:2] != 2'd0 |->
      m_axis_tuser[1:0] == nsf_pkg::NSF_OK)
    else $error("header type on a bad frame");

  // short frames carry no sums
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1:0] == nsf_pkg::NSF_SHORT |->
      m_axis_tdata[7:0] < 8'(nsf_pkg::MinLen) && m_axis_tdata[23:8] == 16'd0)
    else $error("bad short-frame result");

  // abort length is fixed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1:0] == nsf_pkg::NSF_OVERFLOW |->
      m_axis_tdata[7:0] == 8'(nsf_pkg::MaxLen + 1) && m_axis_tdata[23:8] == 16'd0)
    else $error("bad overflow result");

  // input only backs up while a result is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

endmodule

bind nmea_sentence_framer nsf_checker u_nsf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ----- tb/sv/nmea_sentence_framer_chk.sv -----
// Scoreboard for the NMEA sentence framer: predicts frame verdicts and checks the result beats.
`timescale 1ns / 1ps

module nmea_sentence_framer_chk
  import nsf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  input  logic                s_ready_i,
  input  logic [7:0]          s_data_i,
  input  logic                m_valid_i,
  input  logic                m_ready_i,
  input  logic [23:0]         m_data_i,    // [7:0] frame_len, [15:8] calc_sum, [23:16] recv_sum
  input  logic [3:0]          m_user_i,    // [1:0] status, [3:2] sentence_type
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  errors_o,
  output int                  pending_o,
  output int                  verdicts_o,
  output logic                frame_open_o
);

  typedef struct packed {
    nsf_status_e status;
    nsf_type_e   kind;
    logic [7:0]  len;
    logic [7:0]  calc;
    logic [7:0]  recv;
  } verdict_t;

  verdict_t    expected_verdicts[$];
  verdict_t    oldest;

  // register copies
  logic [7:0]  start_ch;
  logic [7:0]  stop_ch;
  logic [47:0] hdr_reg[NumHdr];

  // frame being collected
  int          open_len;
  logic [7:0]  xor_acc;
  logic [47:0] head;
  logic [7:0]  tail[5];

  // {is_hex, value}
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
    if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
    return 5'd0;
  endfunction

  task automatic clear_frame();
    open_len = 0;
    xor_acc  = 8'd0;
    head     = 48'd0;
    foreach (tail[k]) tail[k] = 8'd0;
  endtask

  task automatic post(input nsf_status_e st, input nsf_type_e ty, input int len,
                      input logic [7:0] cs, input logic [7:0] rs);
    expected_verdicts.push_back('{st, ty, 8'(len), cs, rs});
    verdicts_o++;
  endtask

  task automatic take_byte(input logic [7:0] b);
    int         nlen;
    logic [7:0] calc;
    logic [7:0] recv;
    logic [4:0] hi;
    logic [4:0] lo;
    nsf_type_e  kind;
    if (open_len == 0) begin
      if (b == start_ch) begin
        open_len = 1;
        head     = {40'd0, b};
        tail[0]  = b;
      end
      return;
    end
    if (open_len < 6) head = {head[39:0], b};
    xor_acc ^= b;
    for (int k = 4; k > 0; k--) tail[k] = tail[k-1];
    tail[0] = b;
    nlen = open_len + 1;
    if (b != stop_ch) begin
      if (nlen > MaxLen) begin
        post(NSF_OVERFLOW, NSF_TYPE_NONE, nlen, 8'd0, 8'd0);
        clear_frame();
      end else begin
        open_len = nlen;
      end
      return;
    end
    if (nlen < MinLen) begin
      post(NSF_SHORT, NSF_TYPE_NONE, nlen, 8'd0, 8'd0);
    end else begin
      // dropping the last five bytes leaves bytes 1 .. len-6
      calc = xor_acc ^ tail[0] ^ tail[1] ^ tail[2] ^ tail[3] ^ tail[4];
      hi   = nibble_of(tail[3]);
      lo   = nibble_of(tail[2]);
      recv = 8'd0;
      if (hi[4]) recv = lo[4] ? {hi[3:0], lo[3:0]} : {4'd0, hi[3:0]};
      if (calc == recv) begin
        kind = NSF_TYPE_NONE;
        for (int k = 0; k < NumHdr; k++)
          if (head == hdr_reg[k]) kind = nsf_type_e'(2'(k + 1));
        post(NSF_OK, kind, nlen, calc, recv);
      end else begin
        post(NSF_MISMATCH, NSF_TYPE_NONE, nlen, calc, recv);
      end
    end
    clear_frame();
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s expected %0d actual %0d", name, want, got);
      errors_o++;
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start_ch   = StartReset;
      stop_ch    = StopReset;
      hdr_reg[0] = HdrAReset;
      hdr_reg[1] = HdrBReset;
      hdr_reg[2] = HdrCReset;
      clear_frame();
      expected_verdicts.delete();
      errors_o   = 0;
      verdicts_o = 0;
    end else begin
      if (m_valid_i && m_ready_i) begin
        if (expected_verdicts.size() == 0) begin
          $error("result beat with no frame verdict pending");
          errors_o++;
        end else begin
          oldest = expected_verdicts.pop_front();
          check_field("status", oldest.status, m_user_i[1:0]);
          check_field("sentence_type", oldest.kind, m_user_i[3:2]);
          check_field("frame_len", oldest.len, m_data_i[7:0]);
          check_field("calc_sum", oldest.calc, m_data_i[15:8]);
          check_field("recv_sum", oldest.recv, m_data_i[23:16]);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          NSF_CFG_START: start_ch   = cfg_data_i[7:0];
          NSF_CFG_STOP:  stop_ch    = cfg_data_i[7:0];
          NSF_CFG_HDR_A: hdr_reg[0] = cfg_data_i[47:0];
          NSF_CFG_HDR_B: hdr_reg[1] = cfg_data_i[47:0];
          NSF_CFG_HDR_C: hdr_reg[2] = cfg_data_i[47:0];
          default: ;
        endcase
      end
      if (s_valid_i && s_ready_i) take_byte(s_data_i);
    end
    pending_o    = expected_verdicts.size();
    frame_open_o = (open_len != 0);
  end

endmodule

// ----- tb/sv/nmea_sentence_framer_tb.sv -----
// Testbench top for the NMEA sentence framer: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module nmea_sentence_framer_tb;
  import nsf_pkg::*;

  // Run-length guard, in clock cycles. It sits well above the slowest legal run
  // (~550 bytes, each with a full sender gap and receiver stall).
  localparam int CycleLimit = 400000;
  localparam int HoldCycles = 80;     // long receiver hold-off
  localparam int ByteTarget = 500;    // bytes offered before wrapping up
  localparam int VerdictMin = 25;     // result beats wanted before wrapping up

  localparam logic [7:0] AsciiStar = "*";
  localparam logic [7:0] AsciiCr   = 8'h0D;

  typedef enum int {
    SUM_UPPER,      // correct checksum, upper-case hex
    SUM_LOWER,      // correct checksum, lower-case hex
    SUM_WRONG,      // corrupted checksum
    SUM_ODD_HIGH,   // first checksum char is not a hex digit
    SUM_ODD_LOW     // second checksum char is not a hex digit
  } sum_form_e;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata;     // [7:0] byte_in
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [23:0]         m_axis_tdata;     // [7:0] frame_len, [15:8] calc_sum, [23:16] recv_sum
  logic [3:0]          m_axis_tuser;     // [1:0] status, [3:2] sentence_type
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  // scoreboard status
  int   errors;
  int   pending;
  int   verdicts;
  logic frame_open;

  // what the stimulus believes is programmed; used to build sentences
  logic [7:0]  start_sh;
  logic [7:0]  stop_sh;
  logic [47:0] hdr_sh[NumHdr];

  int bytes_sent  = 0;
  int cycle_count = 0;
  bit tx_gaps     = 1'b0;   // sender may insert idle bursts
  bit quiet       = 1'b0;   // closing stretch: no idling on either side
  bit hold_req    = 1'b0;   // ask the receiver for one long hold-off
  bit rx_calm     = 1'b0;   // receiver stall-free stretch

  nmea_sentence_framer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  nmea_sentence_framer_chk frame_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_i    (s_axis_tready),
    .s_data_i     (s_axis_tdata),
    .m_valid_i    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_data_i     (m_axis_tdata),
    .m_user_i     (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .errors_o     (errors),
    .pending_o    (pending),
    .verdicts_o   (verdicts),
    .frame_open_o (frame_open)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Cycle guard: a hung handshake or a lost result ends here.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("nmea_sentence_framer_tb: errors");
    $finish;
  end

  // Receiver side. Random stall bursts, calm stretches, and one long
  // hold-off on request so the output register fills and s_axis backs up.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 63) == 0) rx_calm = !rx_calm;
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (!quiet && !rx_calm && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // One byte beat. Entered and left on a falling edge; tvalid is left high
  // so back-to-back bytes stream without a bubble.
  task automatic send_byte(input logic [7:0] b);
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  // Mostly printable filler; never the stop byte so the frame stays open.
  function automatic logic [7:0] body_byte();
    logic [7:0] c;
    c = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                    : 8'($urandom_range(8'h20, 8'h7E));
    if (c == stop_sh) c ^= 8'h01;
    return c;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit lower);
    if (nib < 4'd10) return 8'("0" + nib);
    return 8'((lower ? "a" : "A") + nib - 8'd10);
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while ((c >= "0" && c <= "9") || (c >= "a" && c <= "f") ||
           (c >= "A" && c <= "F") || c == stop_sh);
    return c;
  endfunction

  // Raw frame of n bytes: start, filler, and the stop byte when close is set.
  // Without close, n bytes are sent and the frame is left to run on.
  task automatic send_run(input int n, input bit close);
    send_byte(start_sh);
    repeat (close ? n - 2 : n - 1) send_byte(body_byte());
    if (close) send_byte(stop_sh);
  endtask

  // Well-formed sentence: start, optional header tail, filler up to nbody
  // bytes after the start, then '*', two checksum chars, CR and stop.
  // hsel 0..2 copies header a..c, anything larger means no header.
  task automatic send_sentence(input int nbody, input int hsel, input sum_form_e form);
    logic [7:0] line[$];
    logic [7:0] sum;
    line.push_back(start_sh);
    if (hsel < NumHdr)
      for (int k = 4; k >= 0; k--) line.push_back(hdr_sh[hsel][k*8 +: 8]);
    while (line.size() < nbody + 1) line.push_back(body_byte());
    sum = 8'd0;
    for (int k = 1; k < line.size(); k++) sum ^= line[k];
    if (form == SUM_WRONG) sum ^= 8'($urandom_range(1, 255));
    line.push_back(AsciiStar);
    case (form)
      SUM_ODD_HIGH: begin
        line.push_back(non_hex_char());
        line.push_back(hex_char(sum[3:0], 1'b0));
      end
      SUM_ODD_LOW: begin
        line.push_back(hex_char(sum[7:4], 1'b0));
        line.push_back(non_hex_char());
      end
      default: begin
        line.push_back(hex_char(sum[7:4], form == SUM_LOWER));
        line.push_back(hex_char(sum[3:0], form == SUM_LOWER));
      end
    endcase
    line.push_back(AsciiCr);
    line.push_back(stop_sh);
    foreach (line[k]) send_byte(line[k]);
  endtask

  // Close any open frame, stop offering, drain every expected result, and
  // give the registered result path time to go quiet.
  task automatic settle();
    while (frame_open) send_byte(stop_sh);
    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (4) @(negedge clk_i);
  endtask

  // One config beat; valid stays up for the next beat.
  task automatic cfg_beat(input nsf_cfg_idx_e idx, input logic [47:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  // Program all five registers; only called with the framer idle.
  task automatic load_config(input logic [7:0] st, input logic [7:0] sp,
                             input logic [47:0] ha, input logic [47:0] hb,
                             input logic [47:0] hc);
    start_sh  = st;
    stop_sh   = sp;
    hdr_sh[0] = ha;
    hdr_sh[1] = hb;
    hdr_sh[2] = hc;
    cfg_beat(NSF_CFG_START, 48'(st));
    cfg_beat(NSF_CFG_STOP, 48'(sp));
    cfg_beat(NSF_CFG_HDR_A, ha);
    cfg_beat(NSF_CFG_HDR_B, hb);
    cfg_beat(NSF_CFG_HDR_C, hc);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [39:0] rand40();
    return {8'($urandom), $urandom};
  endfunction

  // Mix of line noise, short and junk frames, rare max-length frames, and
  // mostly well-formed sentences with random headers and checksum forms.
  task automatic random_phase(input int n);
    int stop_at;
    int pick;
    int f;
    sum_form_e form;
    stop_at = bytes_sent + n;
    while (bytes_sent < stop_at) begin
      tx_gaps = !quiet && ($urandom_range(0, 3) != 0);
      pick    = $urandom_range(0, 99);
      if (pick < 12) begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      end else if (pick < 22) begin
        send_run($urandom_range(2, 9), 1'b1);
      end else if (pick < 24) begin
        send_run($urandom_range(10, 40), 1'b1);
      end else if (pick < 25) begin
        send_run(MaxLen + 1, 1'($urandom_range(0, 1)));
      end else begin
        f = $urandom_range(0, 9);
        case (f)
          0, 1, 2, 3: form = SUM_UPPER;
          4, 5:       form = SUM_LOWER;
          6, 7:       form = SUM_WRONG;
          8:          form = SUM_ODD_HIGH;
          default:    form = SUM_ODD_LOW;
        endcase
        send_sentence($urandom_range(4, 16), $urandom_range(0, 4), form);
      end
    end
  endtask

  initial begin
    logic [7:0] both;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'd0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = NSF_CFG_START;
    cfg_data_i    = '0;
    start_sh      = StartReset;
    stop_sh       = StopReset;
    hdr_sh[0]     = HdrAReset;
    hdr_sh[1]     = HdrBReset;
    hdr_sh[2]     = HdrCReset;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed, reset config: noise while idle, each header, lower-case
    // hex, minimum length, bad checksum, both non-hex digit cases, shorts.
    tx_gaps = 1'b1;
    send_byte(8'h00);
    send_byte(8'hFF);
    send_sentence(7, 0, SUM_UPPER);
    send_sentence(6, 1, SUM_LOWER);
    send_sentence(8, 2, SUM_UPPER);
    send_sentence(4, 3, SUM_UPPER);
    send_sentence(9, 0, SUM_WRONG);
    send_sentence(6, 3, SUM_ODD_HIGH);
    send_sentence(6, 3, SUM_ODD_LOW);
    send_run(9, 1'b1);
    send_run(2, 1'b1);
    settle();

    // Extremes: start 0x00, stop 0xFF, headers a and c equal so c wins.
    // Also an overflow abort and a judged frame of MaxLen + 1 bytes.
    load_config(8'h00, 8'hFF, 48'h0, 48'hFFFF_FFFF_FFFF, 48'h0);
    send_sentence(6, 0, SUM_UPPER);
    send_run(MaxLen + 1, 1'b0);
    send_sentence(MaxLen - 5, 0, SUM_UPPER);
    settle();

    // Opposite extremes, all-ones header b. The receiver holds off while
    // the sender keeps pushing sentences, so the input must stall.
    load_config(8'hFF, 8'h00, {8'hFF, rand40()}, 48'hFFFF_FFFF_FFFF, {8'hFF, rand40()});
    hold_req = 1'b1;
    repeat (6) send_sentence($urandom_range(4, 6), $urandom_range(0, 2), SUM_UPPER);
    settle();
    random_phase(15);
    settle();

    // Start byte equal to stop byte: opens when idle, closes when open.
    both = 8'($urandom_range(0, 255));
    load_config(both, both, {both, rand40()}, {both, rand40()}, {both, rand40()});
    random_phase(25);
    settle();

    // Closing stretch on reset values, no idling on either side.
    quiet = 1'b1;
    load_config(StartReset, StopReset, HdrAReset, HdrBReset, HdrCReset);
    do random_phase(25); while (bytes_sent < ByteTarget || verdicts < VerdictMin);
    settle();
    repeat (8) @(posedge clk_i);

    if (errors == 0 && pending == 0) begin
      $display("nmea_sentence_framer_tb: clean");
    end else begin
      $display("nmea_sentence_framer_tb: errors");
    end
    $finish;
  end

endmodule
